@@ src/ppl_pkg.sv @@
// Shared constants, phase codes and controller/datapath handshake types for the line generator.
package ppl_pkg;

    // Field widths of the channels and the configuration register.
    localparam int POINT_W = 12;
    localparam int ORDER_W = 7;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd2;

    // Default largest number of points per line.
    localparam int MAX_POINTS_PER_LINE = 64;

    // Sequence phases.
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_AFFINE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_VERTICAL = 2'd1;
    localparam logic [PHASE_W-1:0] PH_INFINITY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                step;
        logic                restart;
        logic [PHASE_W-1:0]  phase;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic col_end;
        logic int_last;
        logic slope_last;
        logic q_zero;
    } t_status;

endpackage

@@ src/ppl_if.sv @@
// Valid/ready channel interfaces for the restart requests and the emitted points.

// Request channel: one beat per point to be emitted.
interface ppl_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: one beat per emitted point.
interface ppl_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppl_pkg::POINT_W-1:0]   point_id;
    logic                          last_in_line;
    logic                          last_in_plane;

    modport source (output valid, output point_id, output last_in_line,
                    output last_in_plane, input ready);
    modport sink   (input valid, input point_id, input last_in_line,
                    input last_in_plane, output ready);
endinterface

@@ src/ppl_ctrl.sv @@
// Controller: channel handshake, output valid and the sequence phase state machine.
module ppl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_restart,
    input  logic              i_out_ready,
    input  logic              i_cfg_we,
    input  ppl_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ppl_pkg::t_cmd     o_cmd
);

    logic [ppl_pkg::PHASE_W-1:0] r_phase;
    logic [ppl_pkg::PHASE_W-1:0] n_phase;
    logic [ppl_pkg::PHASE_W-1:0] eff_phase;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        step;

    // A new beat is taken whenever the output register is free or being drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign step        = i_in_valid && o_in_ready;

    // Phase used for this point: a restart goes back to the affine lines, and a
    // plane of order zero only has the line at infinity.
    always_comb begin
        if (i_status.q_zero) begin
            eff_phase = ppl_pkg::PH_INFINITY;
        end else if (i_restart) begin
            eff_phase = ppl_pkg::PH_AFFINE;
        end else begin
            eff_phase = r_phase;
        end
    end

    assign o_cmd.step    = step;
    assign o_cmd.restart = i_restart;
    assign o_cmd.phase   = eff_phase;

    // Phase transitions at the closing point of the last line of each group.
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            case (eff_phase)
                ppl_pkg::PH_AFFINE: begin
                    if (i_status.col_end && i_status.int_last && i_status.slope_last) begin
                        n_phase = ppl_pkg::PH_VERTICAL;
                    end else begin
                        n_phase = ppl_pkg::PH_AFFINE;
                    end
                end
                ppl_pkg::PH_VERTICAL: begin
                    if (i_status.col_end && i_status.slope_last) begin
                        n_phase = ppl_pkg::PH_INFINITY;
                    end else begin
                        n_phase = ppl_pkg::PH_VERTICAL;
                    end
                end
                ppl_pkg::PH_INFINITY: begin
                    if (i_status.col_end) begin
                        n_phase = ppl_pkg::PH_AFFINE;
                    end else begin
                        n_phase = ppl_pkg::PH_INFINITY;
                    end
                end
                default: begin
                    n_phase = ppl_pkg::PH_AFFINE;
                end
            endcase
        end
    end

    // Output valid: set by an accepted beat, cleared when the result is taken.
    always_comb begin
        if (step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State registers; a configuration write returns the sequence to its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ppl_pkg::PH_AFFINE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_phase <= ppl_pkg::PH_AFFINE;
            end else begin
                r_phase <= n_phase;
            end
        end
    end

`ifndef SYNTH
    // A stalled request side always means a result is waiting.
    a_ready_implies_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_out_valid)
        else $error("input stalled with no pending result");

    // Every accepted beat produces a result in the next cycle.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("accepted beat produced no result");

    // The closing point at infinity always wraps back to the affine lines.
    a_plane_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_cfg_we && eff_phase == ppl_pkg::PH_INFINITY && i_status.col_end)
        |=> r_phase == ppl_pkg::PH_AFFINE)
        else $error("sequence did not wrap after the last line");
`endif

endmodule

@@ src/ppl_dp.sv @@
// Datapath: plane order, line counters, point number arithmetic and result register.
module ppl_dp #(
    parameter int MAX_POINTS_PER_LINE = ppl_pkg::MAX_POINTS_PER_LINE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppl_pkg::ORDER_W-1:0]   i_cfg_wdata,
    input  ppl_pkg::t_cmd                 i_cmd,
    output ppl_pkg::t_status              o_status,
    output logic [ppl_pkg::POINT_W-1:0]   o_point_id,
    output logic                          o_last_in_line,
    output logic                          o_last_in_plane
);

    localparam int QW   = $clog2(MAX_POINTS_PER_LINE);
    localparam int PW   = 2 * QW;
    localparam int IDFW = (PW + 1 > ppl_pkg::POINT_W) ? PW + 1 : ppl_pkg::POINT_W;

    // Clamp the points-per-line value into range and turn it into the plane order.
    function automatic logic [QW-1:0] order_to_q(input logic [ppl_pkg::ORDER_W-1:0] k);
        logic [31:0] k_ext;
        logic [31:0] k_sel;
        logic [31:0] q_full;
        k_ext = 32'(k);
        if (k_ext == 32'd0) begin
            k_sel = 32'd1;
        end else if (k_ext > 32'(MAX_POINTS_PER_LINE)) begin
            k_sel = 32'(MAX_POINTS_PER_LINE);
        end else begin
            k_sel = k_ext;
        end
        q_full = k_sel - 32'd1;
        return q_full[QW-1:0];
    endfunction

    logic [QW-1:0]               r_q;
    logic [PW-1:0]               r_qq;
    logic [QW-1:0]               r_col;
    logic [QW-1:0]               r_slope;
    logic [QW-1:0]               r_int;
    logic [QW-1:0]               r_y;
    logic [QW-1:0]               n_col;
    logic [QW-1:0]               n_slope;
    logic [QW-1:0]               n_int;
    logic [QW-1:0]               n_y;
    logic [ppl_pkg::POINT_W-1:0] r_point;
    logic                        r_last_line;
    logic                        r_last_plane;

    logic [ppl_pkg::ORDER_W-1:0] k_src;
    logic [QW-1:0]               cfg_q;
    logic [PW-1:0]               cfg_qq;
    logic [QW-1:0]               q_m1;
    logic [QW-1:0]               e_col;
    logic [QW-1:0]               e_slope;
    logic [QW-1:0]               e_int;
    logic [QW-1:0]               e_y;
    logic                        col_end;
    logic                        int_last;
    logic                        slope_last;
    logic [QW-1:0]               mul_a;
    logic [PW-1:0]               prod;
    logic [QW:0]                 y_sum;
    logic [QW:0]                 y_wrap;
    logic [IDFW-1:0]             id_full;

    // Order and its square, loaded at reset and at every configuration write.
    assign k_src  = i_rst_n ? i_cfg_wdata : ppl_pkg::ORDER_RESET;
    assign cfg_q  = order_to_q(k_src);
    assign cfg_qq = PW'(cfg_q) * PW'(cfg_q);

    // Counter values seen by this point, after an optional restart.
    assign e_col   = i_cmd.restart ? '0 : r_col;
    assign e_slope = i_cmd.restart ? '0 : r_slope;
    assign e_int   = i_cmd.restart ? '0 : r_int;
    assign e_y     = i_cmd.restart ? '0 : r_y;

    // Status for the phase machine.
    assign q_m1       = r_q - QW'(1);
    assign col_end    = (e_col == r_q);
    assign int_last   = (e_int == q_m1);
    assign slope_last = (e_slope == q_m1);

    assign o_status.col_end    = col_end;
    assign o_status.int_last   = int_last;
    assign o_status.slope_last = slope_last;
    assign o_status.q_zero     = (r_q == '0);

    // Row base: column times q in affine lines, x times q in vertical lines.
    assign mul_a = (i_cmd.phase == ppl_pkg::PH_AFFINE) ? e_col : e_slope;
    assign prod  = PW'(mul_a) * PW'(r_q);

    // Next y of an affine line, wrapped modulo q.
    assign y_sum  = {1'b0, e_y} + {1'b0, e_slope};
    assign y_wrap = (y_sum >= {1'b0, r_q}) ? (y_sum - {1'b0, r_q}) : y_sum;

    // One-based point number.
    always_comb begin
        case (i_cmd.phase)
            ppl_pkg::PH_AFFINE: begin
                if (col_end) begin
                    id_full = IDFW'(r_qq) + IDFW'(e_slope) + IDFW'(1);
                end else begin
                    id_full = IDFW'(prod) + IDFW'(e_y) + IDFW'(1);
                end
            end
            ppl_pkg::PH_VERTICAL: begin
                if (col_end) begin
                    id_full = IDFW'(r_qq) + IDFW'(r_q) + IDFW'(1);
                end else begin
                    id_full = IDFW'(prod) + IDFW'(e_col) + IDFW'(1);
                end
            end
            default: begin
                if (col_end) begin
                    id_full = IDFW'(r_qq) + IDFW'(r_q) + IDFW'(1);
                end else begin
                    id_full = IDFW'(r_qq) + IDFW'(e_col) + IDFW'(1);
                end
            end
        endcase
    end

    // Counter updates for the current phase.
    always_comb begin
        n_col   = e_col;
        n_slope = e_slope;
        n_int   = e_int;
        n_y     = e_y;
        case (i_cmd.phase)
            ppl_pkg::PH_AFFINE: begin
                if (!col_end) begin
                    n_col = e_col + QW'(1);
                    n_y   = y_wrap[QW-1:0];
                end else begin
                    n_col = '0;
                    if (int_last) begin
                        n_int   = '0;
                        n_slope = slope_last ? '0 : e_slope + QW'(1);
                    end else begin
                        n_int = e_int + QW'(1);
                    end
                    n_y = int_last ? '0 : e_int + QW'(1);
                end
            end
            ppl_pkg::PH_VERTICAL: begin
                if (!col_end) begin
                    n_col = e_col + QW'(1);
                end else begin
                    n_col   = '0;
                    n_slope = slope_last ? '0 : e_slope + QW'(1);
                end
            end
            default: begin
                if (!col_end) begin
                    n_col = e_col + QW'(1);
                end else begin
                    n_col   = '0;
                    n_slope = '0;
                    n_int   = '0;
                    n_y     = '0;
                end
            end
        endcase
    end

    // Order registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_q  <= cfg_q;
            r_qq <= cfg_qq;
        end
    end

    // Line counters; reset and configuration writes return to the first point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col   <= '0;
            r_slope <= '0;
            r_int   <= '0;
            r_y     <= '0;
        end else if (i_cmd.step) begin
            r_col   <= n_col;
            r_slope <= n_slope;
            r_int   <= n_int;
            r_y     <= n_y;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_point      <= id_full[ppl_pkg::POINT_W-1:0];
            r_last_line  <= col_end;
            r_last_plane <= col_end && (i_cmd.phase == ppl_pkg::PH_INFINITY);
        end
    end

    assign o_point_id      = r_point;
    assign o_last_in_line  = r_last_line;
    assign o_last_in_plane = r_last_plane;

`ifndef SYNTH
    // The column never runs past the closing point.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_q)
        else $error("column counter beyond plane order");

    // y of an affine line stays reduced modulo q.
    a_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q != '0) |-> (r_y < r_q))
        else $error("running y not reduced modulo q");

    // Slope and intercept stay below q.
    a_slope_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q != '0) |-> ((r_slope < r_q) && (r_int < r_q)))
        else $error("slope or intercept counter beyond plane order");
`endif

endmodule

@@ src/projective_plane_line_generator.sv @@
// Top level of the projective plane line generator.
//
// Each beat on i_req asks for one point; its restart bit, when set, makes the
// beat emit the first point of the first line instead of the next one. Each
// beat on o_rsp carries the one-based point number and flags that close the
// current line and the whole plane. Lines come in order: affine lines by
// slope then intercept, each closed by its slope point, then the vertical
// lines, then the line at infinity; after that the sequence starts over.
// i_cfg_we / i_cfg_wdata write the number of points per line (k, reset 2);
// a write also returns the sequence to its first point. Write only while idle.
// A request beat's result is registered and shows at o_rsp in the cycle after
// the beat is accepted. One beat per cycle is sustained while o_rsp is not
// stalled; the next counter values and the row-base multiply are combinational.
// The result register holds while o_rsp is stalled, and i_req stays ready as
// long as that register is empty or being taken in the same cycle.
// Reset is synchronous and active low: no result pending, k = 2, sequence at
// its start. No clearing pass is needed.
module projective_plane_line_generator #(
    parameter int MAX_POINTS_PER_LINE = ppl_pkg::MAX_POINTS_PER_LINE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ppl_in_if.sink                       i_req,
    ppl_out_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [ppl_pkg::ORDER_W-1:0]  i_cfg_wdata
);

    ppl_pkg::t_cmd    cmd;
    ppl_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;

    // Handshake and phase control.
    ppl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_restart   (i_req.restart),
        .i_out_ready (o_rsp.ready),
        .i_cfg_we    (i_cfg_we),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Counters and point arithmetic.
    ppl_dp #(
        .MAX_POINTS_PER_LINE (MAX_POINTS_PER_LINE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_point_id      (o_rsp.point_id),
        .o_last_in_line  (o_rsp.last_in_line),
        .o_last_in_plane (o_rsp.last_in_plane)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule
